>>> sv/location_outlier_filter_core_macros.svh
// assertion macros used by the outlier filter checker
`ifndef LOCATION_OUTLIER_FILTER_CORE_MACROS_SVH
`define LOCATION_OUTLIER_FILTER_CORE_MACROS_SVH

// clocked assertion, quiet while reset is held
`define LOF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LOF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/lof_pkg.sv
// types and constants of the location outlier filter
package lof_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_LEN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_RATIO = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_REJECT  = 2'd3;

    localparam logic [6:0]  MATCH_LEN_RESET   = 7'd8;
    localparam logic [7:0]  ERROR_RATIO_RESET = 8'd8;
    localparam logic [15:0] DISTANCE_RESET    = 16'd100;
    localparam logic [7:0]  MAX_REJECT_RESET  = 8'd3;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [12:0] match_area;
        logic [7:0]  row_errors;
        logic [7:0]  row_samples;
        logic [7:0]  col_errors;
        logic [7:0]  col_samples;
    } fix_t;

    typedef struct packed {
        logic        accepted;
        logic [15:0] held_x;
        logic [15:0] held_y;
    } result_t;

    typedef struct packed {
        logic [6:0]  min_side;
        logic [7:0]  error_ratio_threshold;
        logic [15:0] jump_limit;
        logic [7:0]  max_rejections;
    } cfg_t;

    // classified fix waiting for the decision stage
    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        quality_fail;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> sv/lof_chan_if.sv
// valid/ready channel carrying one item per handshake
interface lof_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport mon (input valid, input data, input ready);
endinterface

>>> sv/location_outlier_filter_core.sv
// top level of the location outlier filter
// an item taken is written into the fifo, then popped into the output register that drives result
// throughput: one item per cycle while the receiver takes results; the decision on the stored position is combinational
// a two-entry fifo parts grading from decision and holds up to two items while a result waits
// reset clears stored position, rejection run, fifo and output valid
// configuration returns to length 8, ratio 8, distance 100, max rejections 3
module location_outlier_filter_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lof_chan_if.sink                        fix,
    lof_chan_if.source                      result,
    input  logic                            cfg_we,
    input  logic [lof_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lof_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    // configuration registers; the user is to write them only while the block is idle, the block does not enforce it
    lof_pkg::cfg_t          cfg_reg;
    lof_pkg::cfg_t          cfg_next;

    // front to fifo
    logic                   push;
    lof_pkg::entry_t        push_entry;

    // fifo to back
    logic                   pop;
    lof_pkg::entry_t        head;
    lof_pkg::queue_status_t q_status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lof_pkg::CFG_MATCH_LEN:
                    cfg_next.min_side = cfg_wdata[6:0];
                lof_pkg::CFG_ERROR_RATIO:
                    cfg_next.error_ratio_threshold = cfg_wdata[7:0];
                lof_pkg::CFG_DISTANCE:
                    cfg_next.jump_limit = cfg_wdata;
                lof_pkg::CFG_MAX_REJECT:
                    cfg_next.max_rejections = cfg_wdata[7:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_side              <= lof_pkg::MATCH_LEN_RESET;
            cfg_reg.error_ratio_threshold <= lof_pkg::ERROR_RATIO_RESET;
            cfg_reg.jump_limit            <= lof_pkg::DISTANCE_RESET;
            cfg_reg.max_rejections        <= lof_pkg::MAX_REJECT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // grading: match size against squared side length, errors against samples
    lof_front u_front (
        .fix        (fix),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // graded fixes wait here when the output side stalls
    lof_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    // decision against stored position, rejection run and output register
    lof_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .result   (result)
    );
endmodule

>>> sv/lof_front.sv
// front stage: takes fixes and grades match size and code noise
module lof_front (
    lof_chan_if.sink              fix,
    input  lof_pkg::cfg_t          cfg,
    input  lof_pkg::queue_status_t q_status,
    output logic                   push,
    output lof_pkg::entry_t        push_entry
);
    logic [13:0] min_area;
    logic [15:0] row_weight;
    logic [15:0] col_weight;
    logic        too_small;
    logic        too_noisy;

    assign fix.ready = !q_status.full;
    assign push      = fix.valid && !q_status.full;

    always_comb
    begin
        min_area   = 14'(cfg.min_side) * 14'(cfg.min_side);
        row_weight = 16'(fix.data.row_errors) * 16'(cfg.error_ratio_threshold);
        col_weight = 16'(fix.data.col_errors) * 16'(cfg.error_ratio_threshold);
        too_small  = 14'(fix.data.match_area) < min_area;
        too_noisy  = (row_weight > 16'(fix.data.row_samples))
                  || (col_weight > 16'(fix.data.col_samples));
        push_entry.pos_x        = fix.data.pos_x;
        push_entry.pos_y        = fix.data.pos_y;
        push_entry.quality_fail = too_small || too_noisy;
    end
endmodule

>>> sv/lof_queue.sv
// small fifo between the grading and decision stages
module lof_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lof_pkg::entry_t        push_entry,
    input  logic                   pop,
    output lof_pkg::entry_t        head,
    output lof_pkg::queue_status_t q_status
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    lof_pkg::entry_t  slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head           = slots_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == FULL);
    assign q_status.empty = (count_reg == '0);
endmodule

>>> sv/lof_back.sv
// back stage: position and run-length decision, output register
module lof_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lof_pkg::cfg_t          cfg,
    input  lof_pkg::queue_status_t q_status,
    input  lof_pkg::entry_t        head,
    output logic                   pop,
    lof_chan_if.source             result
);
    logic [15:0]      stored_x_reg;
    logic [15:0]      stored_x_next;
    logic [15:0]      stored_y_reg;
    logic [15:0]      stored_y_next;
    logic [8:0]       reject_run_reg;
    logic [8:0]       reject_run_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    lof_pkg::result_t out_data_reg;
    lof_pkg::result_t out_data_next;

    logic [15:0] dx;
    logic [15:0] dy;
    logic [8:0]  run_inc;
    logic        same_pos;
    logic        far;
    logic        forced;
    logic        ok;

    assign pop = !q_status.empty && (!out_valid_reg || result.ready);

    always_comb
    begin
        dx       = (head.pos_x >= stored_x_reg) ? head.pos_x - stored_x_reg
                                                : stored_x_reg - head.pos_x;
        dy       = (head.pos_y >= stored_y_reg) ? head.pos_y - stored_y_reg
                                                : stored_y_reg - head.pos_y;
        same_pos = (head.pos_x == stored_x_reg) && (head.pos_y == stored_y_reg);
        far      = (dx > cfg.jump_limit) || (dy > cfg.jump_limit);
        run_inc  = reject_run_reg + 9'd1;
        forced   = run_inc > {1'b0, cfg.max_rejections};

        stored_x_next   = stored_x_reg;
        stored_y_next   = stored_y_reg;
        reject_run_next = reject_run_reg;
        ok              = 1'b0;

        if (same_pos)
        begin
            ok = 1'b1;
        end
        else if (head.quality_fail)
        begin
            ok = 1'b0;
        end
        else if (far)
        begin
            // far jump: count it, force through once the run is too long
            if (forced)
            begin
                reject_run_next = '0;
                stored_x_next   = head.pos_x;
                stored_y_next   = head.pos_y;
                ok              = 1'b1;
            end
            else
            begin
                reject_run_next = run_inc;
            end
        end
        else
        begin
            reject_run_next = '0;
            stored_x_next   = head.pos_x;
            stored_y_next   = head.pos_y;
            ok              = 1'b1;
        end

        out_data_next.accepted = ok;
        out_data_next.held_x   = stored_x_next;
        out_data_next.held_y   = stored_y_next;

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_x_reg   <= '0;
            stored_y_reg   <= '0;
            reject_run_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                stored_x_reg   <= stored_x_next;
                stored_y_reg   <= stored_y_next;
                reject_run_reg <= reject_run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
endmodule

>>> sv/lof_checker.sv
// port-level checks for the location outlier filter
`include "location_outlier_filter_core_macros.svh"

module lof_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             fix_valid,
    input logic             fix_ready,
    input logic             res_valid,
    input logic             res_ready,
    input lof_pkg::result_t res_data
);
    logic             fix_fire;
    logic             res_fire;
    logic             held_same;
    logic [3:0]       pending_reg;
    logic [3:0]       pending_next;
    logic [15:0]      last_x_reg;
    logic [15:0]      last_y_reg;

    assign fix_fire  = fix_valid && fix_ready;
    assign res_fire  = res_valid && res_ready;
    assign held_same = (res_data.held_x == last_x_reg) && (res_data.held_y == last_y_reg);

    always_comb
    begin
        pending_next = pending_reg + 4'(fix_fire) - 4'(res_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (res_fire)
            begin
                last_x_reg <= res_data.held_x;
                last_y_reg <= res_data.held_y;
            end
        end
    end

    `LOF_ASSERT(a_result_held, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
    `LOF_ASSERT(a_no_phantom, res_valid |-> pending_reg != 4'd0, "result without a pending item")
    `LOF_ASSERT(a_reject_keeps, res_fire && !res_data.accepted |-> held_same, "rejected item moved position")
    `LOF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !res_valid, "result valid after a reset cycle")
endmodule

bind location_outlier_filter_core lof_checker u_lof_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .fix_valid (fix.valid),
    .fix_ready (fix.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

>>> tb/sv/tb_location_outlier_filter_core.sv
// testbench for the location outlier filter: queued fixes, shadow filter, in-order result check
module tb_location_outlier_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    // long receiver hold-off, well past the internal fifo depth
    localparam int HOLD_CYCLES  = 80;
    // cycles to let pass after the last result
    localparam int SETTLE_CYCLES = 8;
    // generous bound on the whole run, in nanoseconds
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;
    localparam int MAX_REPORTS = 10;

    // receiver stall patterns
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_CYCLIC
    } ready_mode_t;

    // ways a fix can fail the quality checks
    typedef enum logic [1:0] {
        FLAW_AREA,
        FLAW_ROW,
        FLAW_COL
    } flaw_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [lof_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lof_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    lof_chan_if #(.payload_t(lof_pkg::fix_t))    fix_ch ();
    lof_chan_if #(.payload_t(lof_pkg::result_t)) res_ch ();

    location_outlier_filter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .fix       (fix_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // shadow copy of the filter state and its registers
    lof_pkg::cfg_t shadow_cfg;
    logic [15:0]   held_x;
    logic [15:0]   held_y;
    logic [8:0]    far_run;

    // fixes waiting to be offered, and verdicts waiting for their result
    lof_pkg::fix_t    fixes_to_send[$];
    lof_pkg::result_t predicted_verdicts[$];

    int unsigned fixes_issued = 0;
    int unsigned fixes_taken  = 0;
    int unsigned fail_count   = 0;
    logic        fix_took     = 1'b0;

    // sender burst state
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall state
    ready_mode_t ready_mode = READY_ALWAYS;
    int mode_left    = 0;
    int cyc_phase    = 0;
    int hold_left    = 0;
    int holds_asked  = 0;
    int holds_served = 0;

    // nominal track that well-behaved fixes follow
    int trk_x;
    int trk_y;

    // decide one fix against the shadow state, update it, return the result
    function automatic lof_pkg::result_t judge_fix(lof_pkg::fix_t f);
        int unsigned      min_area;
        int unsigned      ratio;
        int unsigned      dx;
        int unsigned      dy;
        logic             ok;
        lof_pkg::result_t r;
        min_area = int'(shadow_cfg.min_side) * int'(shadow_cfg.min_side);
        ratio = shadow_cfg.error_ratio_threshold;
        dx = (f.pos_x >= held_x) ? int'(f.pos_x) - int'(held_x) : int'(held_x) - int'(f.pos_x);
        dy = (f.pos_y >= held_y) ? int'(f.pos_y) - int'(held_y) : int'(held_y) - int'(f.pos_y);
        if (f.pos_x == held_x && f.pos_y == held_y) begin
            // repeat of the held position wins over every other rule
            ok = 1'b1;
        end
        else if (int'(f.match_area) < min_area) begin
            ok = 1'b0;
        end
        else if (int'(f.row_errors) * ratio > int'(f.row_samples)
                 || int'(f.col_errors) * ratio > int'(f.col_samples)) begin
            ok = 1'b0;
        end
        else if (dx > shadow_cfg.jump_limit || dy > shadow_cfg.jump_limit) begin
            far_run = far_run + 9'd1;
            if (far_run > shadow_cfg.max_rejections) begin
                // too many far rejections in a row, take the jump
                far_run = '0;
                held_x = f.pos_x;
                held_y = f.pos_y;
                ok = 1'b1;
            end
            else begin
                ok = 1'b0;
            end
        end
        else begin
            far_run = '0;
            held_x = f.pos_x;
            held_y = f.pos_y;
            ok = 1'b1;
        end
        r.accepted = ok;
        r.held_x = held_x;
        r.held_y = held_y;
        return r;
    endfunction

    function automatic int clamp16(int v);
        return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
    endfunction

    function automatic lof_pkg::fix_t fix_of(int x, int y, int area, int re, int rs,
                                             int ce, int cs);
        lof_pkg::fix_t f;
        f.pos_x = 16'(x);
        f.pos_y = 16'(y);
        f.match_area = 13'(area);
        f.row_errors = 8'(re);
        f.row_samples = 8'(rs);
        f.col_errors = 8'(ce);
        f.col_samples = 8'(cs);
        return f;
    endfunction

    // fix that passes both quality checks, unless the squared length is above 8191
    function automatic lof_pkg::fix_t sound_fix(int x, int y);
        int unsigned   min_area;
        int unsigned   ratio;
        lof_pkg::fix_t f;
        min_area = int'(shadow_cfg.min_side) * int'(shadow_cfg.min_side);
        ratio = shadow_cfg.error_ratio_threshold;
        f.pos_x = 16'(x);
        f.pos_y = 16'(y);
        f.match_area = (min_area > 8191) ? 13'd8191 : 13'($urandom_range(8191, min_area));
        f.row_samples = 8'($urandom_range(0, 255));
        f.col_samples = 8'($urandom_range(0, 255));
        if (ratio == 0) begin
            f.row_errors = 8'($urandom);
            f.col_errors = 8'($urandom);
        end
        else begin
            f.row_errors = 8'($urandom_range(0, f.row_samples / ratio));
            f.col_errors = 8'($urandom_range(0, f.col_samples / ratio));
        end
        return f;
    endfunction

    // fix that fails one quality check, when the registers allow a failure
    function automatic lof_pkg::fix_t faulty_fix(int x, int y);
        int unsigned   min_area;
        int unsigned   ratio;
        int unsigned   smp;
        flaw_t         flaw;
        lof_pkg::fix_t f;
        min_area = int'(shadow_cfg.min_side) * int'(shadow_cfg.min_side);
        ratio = shadow_cfg.error_ratio_threshold;
        f = sound_fix(x, y);
        flaw = flaw_t'($urandom_range(0, 2));
        if (min_area == 0 && flaw == FLAW_AREA)
            flaw = FLAW_ROW;
        if (ratio == 0 && flaw != FLAW_AREA)
            flaw = FLAW_AREA;
        smp = $urandom_range(0, 254);
        case (flaw)
            FLAW_AREA: begin
                if (min_area > 0)
                    f.match_area = 13'($urandom_range(0, (min_area > 8192) ? 8191 : min_area - 1));
            end
            FLAW_ROW: begin
                f.row_samples = 8'(smp);
                f.row_errors = 8'($urandom_range(smp / ratio + 1, 255));
            end
            default: begin
                f.col_samples = 8'(smp);
                f.col_errors = 8'($urandom_range(smp / ratio + 1, 255));
            end
        endcase
        return f;
    endfunction

    function automatic lof_pkg::fix_t noise_fix();
        return fix_of($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 8191), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
    endfunction

    // mostly a plausible track with outlier runs, bad codes and some noise
    task automatic queue_mixed_fixes(int count);
        int n;
        int kind;
        int stride;
        int reach;
        int jump;
        int sx;
        int sy;
        int run_len;
        n = 0;
        reach = shadow_cfg.jump_limit;
        stride = (reach < 2000) ? reach : 2000;
        while (n < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                // near move along the track, sometimes exactly on the threshold
                if ($urandom_range(0, 9) == 0) begin
                    trk_x = (trk_x + reach <= 65535) ? trk_x + reach : trk_x;
                end
                else begin
                    trk_x = clamp16(trk_x + int'($urandom_range(0, 2 * stride)) - stride);
                    trk_y = clamp16(trk_y + int'($urandom_range(0, 2 * stride)) - stride);
                end
                fixes_to_send.push_back(sound_fix(trk_x, trk_y));
                n++;
            end
            else if (kind < 65) begin
                // repeat of the track position, quality does not matter here
                fixes_to_send.push_back($urandom_range(0, 1) ? faulty_fix(trk_x, trk_y)
                                                             : sound_fix(trk_x, trk_y));
                n++;
            end
            else if (kind < 77) begin
                sx = clamp16(trk_x + int'($urandom_range(0, 40)) - 20);
                sy = clamp16(trk_y + int'($urandom_range(0, 40)) - 20);
                fixes_to_send.push_back(faulty_fix(sx, sy));
                n++;
            end
            else if (kind < 90) begin
                // run of far fixes at one spot, long enough to force it now and then
                jump = reach + 1 + int'($urandom_range(0, 3000));
                if (jump > 65535)
                    jump = 65535;
                if (trk_x + jump <= 65535)
                    sx = trk_x + jump;
                else if (trk_x >= jump)
                    sx = trk_x - jump;
                else
                    sx = (trk_x > 32767) ? 0 : 65535;
                sy = clamp16(trk_y + int'($urandom_range(0, 20)) - 10);
                run_len = $urandom_range(1, int'(shadow_cfg.max_rejections) + 2);
                if (run_len > 12)
                    run_len = 12;
                for (int i = 0; i < run_len && n < count; i++) begin
                    if ($urandom_range(0, 4) == 0)
                        fixes_to_send.push_back(faulty_fix(sx, sy));
                    else
                        fixes_to_send.push_back(sound_fix(sx, sy));
                    n++;
                end
                if (run_len > shadow_cfg.max_rejections) begin
                    trk_x = sx;
                    trk_y = sy;
                end
            end
            else begin
                fixes_to_send.push_back(noise_fix());
                n++;
            end
        end
    endtask

    // register write at the next falling edge, shadow copy follows
    task automatic write_reg(input logic [lof_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lof_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            lof_pkg::CFG_MATCH_LEN:   shadow_cfg.min_side = value[6:0];
            lof_pkg::CFG_ERROR_RATIO: shadow_cfg.error_ratio_threshold = value[7:0];
            lof_pkg::CFG_DISTANCE:    shadow_cfg.jump_limit = value[15:0];
            lof_pkg::CFG_MAX_REJECT:  shadow_cfg.max_rejections = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // all four registers, junk in the unused upper bits
    task automatic write_all(int len, int ratio, int reach, int max_rej);
        write_reg(lof_pkg::CFG_MATCH_LEN, {9'($urandom), 7'(len)});
        write_reg(lof_pkg::CFG_ERROR_RATIO, {8'($urandom), 8'(ratio)});
        write_reg(lof_pkg::CFG_DISTANCE, 16'(reach));
        write_reg(lof_pkg::CFG_MAX_REJECT, {8'($urandom), 8'(max_rej)});
    endtask

    // nothing queued, nothing in flight, no verdict outstanding
    task automatic wait_drained();
        @(posedge clk);
        while (fixes_to_send.size() != 0 || fixes_issued != fixes_taken
               || predicted_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // track restarts from the held position once the block is idle
    task automatic snap_track();
        trk_x = held_x;
        trk_y = held_y;
    endtask

    // sender: offer queued fixes in bursts, hold an item until it is taken
    always @(negedge clk) begin
        if (!rst_n) begin
            fix_ch.valid <= 1'b0;
        end
        else if (!fix_ch.valid || fix_took) begin
            if (gap_left > 0) begin
                gap_left--;
                fix_ch.valid <= 1'b0;
            end
            else if (fixes_to_send.size() > 0) begin
                fix_ch.data <= fixes_to_send.pop_front();
                fix_ch.valid <= 1'b1;
                fixes_issued++;
                if (burst_left > 1) begin
                    burst_left--;
                end
                else begin
                    // new burst; a third of the time no gap at all
                    burst_left = $urandom_range(1, 60);
                    if ($urandom_range(0, 2) == 0)
                        gap_left = 0;
                    else if ($urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(5, 15);
                    else
                        gap_left = $urandom_range(1, 3);
                end
            end
            else begin
                fix_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            res_ch.ready <= 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (ready_mode)
                READY_ALWAYS: res_ch.ready <= 1'b1;
                READY_HALF:   res_ch.ready <= 1'($urandom_range(0, 1));
                READY_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    cyc_phase++;
                    res_ch.ready <= (cyc_phase % 3 != 0);
                end
            endcase
        end
    end

    // monitor: predict on every taken fix, check every taken result in order
    always @(posedge clk) begin : watch_ports
        lof_pkg::result_t want;
        fix_took <= fix_ch.valid && fix_ch.ready;
        if (rst_n) begin
            if (fix_ch.valid && fix_ch.ready) begin
                predicted_verdicts.push_back(judge_fix(fix_ch.data));
                fixes_taken++;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (predicted_verdicts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: accepted %0d held (%0d, %0d)",
                                 res_ch.data.accepted, res_ch.data.held_x, res_ch.data.held_y);
                end
                else begin
                    want = predicted_verdicts.pop_front();
                    if (res_ch.data.accepted !== want.accepted
                        || res_ch.data.held_x !== want.held_x
                        || res_ch.data.held_y !== want.held_y) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"result mismatch: accepted %0d/%0d held_x %0d/%0d",
                                      " held_y %0d/%0d (expected/actual)"},
                                     want.accepted, res_ch.data.accepted,
                                     want.held_x, res_ch.data.held_x,
                                     want.held_y, res_ch.data.held_y);
                    end
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb_location_outlier_filter_core: FAIL");
        $finish;
    end

    // stimulus phases
    initial begin : stimulus
        int spot;
        fix_ch.valid = 1'b0;
        fix_ch.data = '0;
        res_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;

        // shadow state after reset
        shadow_cfg.min_side = lof_pkg::MATCH_LEN_RESET;
        shadow_cfg.error_ratio_threshold = lof_pkg::ERROR_RATIO_RESET;
        shadow_cfg.jump_limit = lof_pkg::DISTANCE_RESET;
        shadow_cfg.max_rejections = lof_pkg::MAX_REJECT_RESET;
        held_x = '0;
        held_y = '0;
        far_run = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed part on reset registers: length 8, ratio 8, distance 100, max 3
        // same position accepted despite bad area and noisy codes
        fixes_to_send.push_back(fix_of(0, 0, 0, 255, 0, 255, 0));
        // area one below the square of the length
        fixes_to_send.push_back(fix_of(50, 60, 63, 0, 0, 0, 0));
        // row code one error too many
        fixes_to_send.push_back(fix_of(50, 60, 64, 1, 7, 0, 0));
        // column code one error too many
        fixes_to_send.push_back(fix_of(50, 60, 64, 1, 8, 1, 7));
        // both codes exactly on the ratio, accepted
        fixes_to_send.push_back(fix_of(50, 60, 64, 1, 8, 1, 8));
        // jump of exactly the distance, accepted
        fixes_to_send.push_back(fix_of(150, 60, 4096, 0, 0, 0, 0));
        // jump one past on x, then a far jump on y
        fixes_to_send.push_back(fix_of(251, 60, 4096, 0, 255, 0, 255));
        fixes_to_send.push_back(fix_of(150, 261, 4096, 0, 255, 0, 255));
        // far corner twice: third rejection, then forced acceptance
        fixes_to_send.push_back(fix_of(65535, 65535, 8191, 31, 255, 31, 255));
        fixes_to_send.push_back(fix_of(65535, 65535, 8191, 31, 255, 31, 255));
        // full-scale jump back to the origin, compared without wrap
        fixes_to_send.push_back(fix_of(0, 0, 8191, 0, 0, 0, 0));
        // repeat of the held corner
        fixes_to_send.push_back(fix_of(65535, 65535, 0, 0, 0, 0, 0));
        // near move clears the run
        fixes_to_send.push_back(fix_of(65500, 65535, 100, 2, 16, 3, 24));
        // far fixes with two bad ones in between that leave the run alone
        fixes_to_send.push_back(fix_of(0, 65535, 64, 0, 0, 0, 0));
        fixes_to_send.push_back(fix_of(0, 65535, 0, 0, 0, 0, 0));
        fixes_to_send.push_back(fix_of(0, 65535, 8191, 255, 255, 0, 0));
        fixes_to_send.push_back(fix_of(0, 65535, 64, 0, 0, 0, 0));
        fixes_to_send.push_back(fix_of(0, 65535, 64, 0, 0, 0, 0));
        fixes_to_send.push_back(fix_of(0, 65535, 64, 0, 0, 0, 0));
        // near the new spot, all-ones samples, zero errors
        fixes_to_send.push_back(fix_of(99, 65436, 64, 0, 255, 0, 255));
        wait_drained();

        // no quality checks, every far fix forced at once; long receiver hold-off
        write_all(0, 0, 100, 0);
        snap_track();
        holds_asked++;
        queue_mixed_fixes(120);
        wait_drained();

        // top extremes: length 127 from an all-ones write, widest distance
        write_reg(lof_pkg::CFG_MATCH_LEN, 16'hFFFF);
        write_reg(lof_pkg::CFG_ERROR_RATIO, 16'hFFFF);
        write_reg(lof_pkg::CFG_DISTANCE, 16'hFFFF);
        write_reg(lof_pkg::CFG_MAX_REJECT, 16'hFFFF);
        snap_track();
        queue_mixed_fixes(50);
        wait_drained();

        // length 64, ratio 1, zero distance, no tolerance for far fixes
        write_all(64, 1, 0, 0);
        snap_track();
        queue_mixed_fixes(50);
        wait_drained();

        // longest possible run: 255 rejections, the next one forced
        write_all(1, 0, 10, 255);
        spot = held_x ^ 16'h8000;
        for (int i = 0; i < 260; i++)
            fixes_to_send.push_back(sound_fix(spot, held_y));
        trk_x = spot;
        trk_y = held_y;
        queue_mixed_fixes(20);
        wait_drained();

        // run built under a high maximum, then the maximum lowered beneath it
        write_all(0, 0, 10, 10);
        spot = held_x ^ 16'h8000;
        for (int i = 0; i < 8; i++)
            fixes_to_send.push_back(sound_fix(spot, held_y));
        wait_drained();
        write_reg(lof_pkg::CFG_MAX_REJECT, 16'd2);
        fixes_to_send.push_back(sound_fix(spot, held_y));
        wait_drained();
        snap_track();
        queue_mixed_fixes(30);
        wait_drained();

        // random settings, the first one with another long hold-off
        for (int p = 0; p < 4; p++) begin
            write_all(($urandom_range(0, 4) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 12),
                      ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 16),
                      ($urandom_range(0, 2) == 0) ? $urandom_range(0, 300)
                          : (($urandom_range(0, 1) == 0) ? $urandom_range(300, 5000)
                                                         : $urandom_range(0, 65535)),
                      $urandom_range(0, 6));
            snap_track();
            if (p == 0)
                holds_asked++;
            queue_mixed_fixes(125);
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        fail_count += predicted_verdicts.size();
        if (fail_count == 0)
            $display("tb_location_outlier_filter_core: PASS");
        else
            $display("tb_location_outlier_filter_core: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/lof_pkg.sv
sv/lof_chan_if.sv
sv/lof_front.sv
sv/lof_queue.sv
sv/lof_back.sv
sv/location_outlier_filter_core.sv
sv/lof_checker.sv
tb/sv/tb_location_outlier_filter_core.sv
